// ----- hw/rtl/rcpc_pkg.sv -----
package rcpc_pkg;

   // pulse-to-level mapping: 1000..2000 us onto 0..255, truncating
   localparam int unsigned MAP_IN_LOW   = 1000;
   localparam int unsigned MAP_IN_SPAN  = 1000;
   localparam int unsigned MAP_OUT_MAX  = 255;
   // smallest offset above MAP_IN_LOW whose scaled value clamps to MAP_OUT_MAX
   localparam int unsigned MAP_SAT_OFS  = 1004;
   // offset bits that matter below saturation, and width of the scaled product
   localparam int unsigned OFS_BITS     = 10;
   localparam int unsigned PROD_BITS    = 18;

   localparam int unsigned CSR_DATA_BITS = 16;
   localparam int unsigned CSR_IDX_BITS  = 3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_VALID_LOW   = 3'd0,
      CSR_VALID_HIGH  = 3'd1,
      CSR_PRESS_LEVEL = 3'd2,
      CSR_LONG_PRESS  = 3'd3,
      CSR_DOUBLE_CLK  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_CLICK      = 2'd0,
      KIND_DOUBLE     = 2'd1,
      KIND_LONG       = 2'd2,
      KIND_CLICK_LONG = 2'd3
   } click_kind_type;

   localparam logic [1:0] TALLY_ONE = 2'd1;
   localparam logic [1:0] TALLY_MAX = 2'd3;

endpackage

// ----- hw/rtl/rc_pulse_click_classifier_unit.sv -----
// rc pulse click classifier
//
// req channel: one beat per rc frame, carrying the measured pulse width (us)
// and a free-running millisecond timestamp. rsp channel: exactly one beat per
// req beat, in order, carrying signal_valid, event_valid and click_kind.
// csr port: plain write (csr_wr_en, csr_index, csr_wdata), no wait state;
// it is to be written only while the block is idle; the block does not enforce this.
//
// a req beat accepted at one clock edge goes input register -> classification
// logic -> result register, and the result register drives rsp.
// throughput: one beat per cycle unless rsp stalls; the gesture state (press
// edges, tally, timestamps) is updated as an item moves from the input register
// into the result register, so back-to-back beats see each other's effects in order.
//
// a stalled rsp keeps the result register; the input register still takes one
// more beat, and req_ready drops only when both registers are full and
// rsp_ready is low.
//
// reset: synchronous, active high; clears both registers' valid flags, the
// gesture state, and loads the csr defaults (900, 2100, 127, 1000, 300).
module rc_pulse_click_classifier_unit
   import rcpc_pkg::*;
#(
   parameter int unsigned TIME_BITS  = 32,
   parameter int unsigned PULSE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [PULSE_BITS-1:0]    req_pulse_width_us,
   input  logic [TIME_BITS-1:0]     req_now_ms,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_signal_valid,
   output logic                     rsp_event_valid,
   output logic [1:0]               rsp_click_kind,
   // configuration writes
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int unsigned CMP_BITS = (PULSE_BITS > CSR_DATA_BITS) ? PULSE_BITS : CSR_DATA_BITS;

   // configuration registers
   logic [15:0] valid_low_ff, valid_high_ff, long_press_ff, double_clk_ff;
   logic [7:0]  press_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_low_ff   <= 16'd900;
         valid_high_ff  <= 16'd2100;
         press_level_ff <= 8'd127;
         long_press_ff  <= 16'd1000;
         double_clk_ff  <= 16'd300;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_VALID_LOW:   valid_low_ff   <= csr_wdata;
            CSR_VALID_HIGH:  valid_high_ff  <= csr_wdata;
            CSR_PRESS_LEVEL: press_level_ff <= csr_wdata[7:0];
            CSR_LONG_PRESS:  long_press_ff  <= csr_wdata;
            CSR_DOUBLE_CLK:  double_clk_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   logic                  in_valid_ff;
   logic [PULSE_BITS-1:0] in_width_ff;
   logic [TIME_BITS-1:0]  in_now_ff;
   logic                  out_valid_ff;
   logic                  advance;

   // item moves on whenever the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_width_ff <= req_pulse_width_us;
         in_now_ff   <= req_now_ms;
      end
   end

   // window check
   logic win_ok;
   assign win_ok = (CMP_BITS'(in_width_ff) >= CMP_BITS'(valid_low_ff)) &&
                   (CMP_BITS'(in_width_ff) <= CMP_BITS'(valid_high_ff));

   // press decision without a divider:
   // floor(ofs*255/1000) > level  <=>  ofs*255 >= (level+1)*1000
   // offsets of MAP_SAT_OFS and more clamp to 255
   logic [PULSE_BITS-1:0] ofs;
   logic                  above_low, saturated, pressed;
   logic [PROD_BITS-1:0]  scaled, thresh;

   assign above_low = in_width_ff >= PULSE_BITS'(MAP_IN_LOW);
   assign ofs       = in_width_ff - PULSE_BITS'(MAP_IN_LOW);
   assign saturated = ofs >= PULSE_BITS'(MAP_SAT_OFS);
   assign scaled    = PROD_BITS'(ofs[OFS_BITS-1:0]) * PROD_BITS'(MAP_OUT_MAX);
   assign thresh    = PROD_BITS'({1'b0, press_level_ff} + 9'd1) * PROD_BITS'(MAP_IN_SPAN);
   assign pressed   = above_low && (press_level_ff != 8'(MAP_OUT_MAX)) &&
                      (saturated || (scaled >= thresh));

   // gesture state
   logic                 is_down_ff, is_down_in;
   logic                 long_seen_ff, long_seen_in;
   logic [1:0]           tally_ff, tally_in;
   logic [TIME_BITS-1:0] down_stamp_ff, down_stamp_in;
   logic [TIME_BITS-1:0] up_stamp_ff, up_stamp_in;
   logic                 armed_ff, armed_in;

   logic                 fire;
   logic [TIME_BITS-1:0] held_time, idle_time;
   click_kind_type       kind;

   always_comb begin
      is_down_in    = is_down_ff;
      long_seen_in  = long_seen_ff;
      tally_in      = tally_ff;
      down_stamp_in = down_stamp_ff;
      up_stamp_in   = up_stamp_ff;
      armed_in      = armed_ff;
      held_time     = in_now_ff - down_stamp_ff;
      fire          = 1'b0;
      kind          = KIND_CLICK;

      // press / release edges
      if (pressed && !is_down_ff) begin
         is_down_in    = 1'b1;
         down_stamp_in = in_now_ff;
         if (tally_ff != TALLY_MAX) begin
            tally_in = tally_ff + 2'd1;
         end
      end else if (!pressed && is_down_ff) begin
         is_down_in  = 1'b0;
         up_stamp_in = in_now_ff;
         if (held_time >= TIME_BITS'(long_press_ff)) begin
            long_seen_in = 1'b1;
         end
         if (tally_ff == TALLY_ONE) begin
            armed_in = 1'b1;
         end
      end

      // single click waits out the double-click window, others end on release
      idle_time = in_now_ff - up_stamp_in;
      fire = !is_down_in &&
             ((tally_in == TALLY_ONE && armed_in &&
               idle_time > TIME_BITS'(double_clk_ff)) ||
              tally_in > TALLY_ONE);

      priority if (long_seen_in && tally_in == TALLY_ONE) begin
         kind = KIND_LONG;
      end else if (long_seen_in && tally_in > TALLY_ONE) begin
         kind = KIND_CLICK_LONG;
      end else if (tally_in > TALLY_ONE) begin
         kind = KIND_DOUBLE;
      end else if (long_seen_in) begin
         kind = KIND_LONG;
      end else begin
         kind = KIND_CLICK;
      end

      if (fire) begin
         armed_in     = 1'b0;
         tally_in     = 2'd0;
         long_seen_in = 1'b0;
      end
   end

   // invalid pulses leave the state untouched
   always_ff @(posedge clock) begin
      if (reset) begin
         is_down_ff    <= 1'b0;
         long_seen_ff  <= 1'b0;
         tally_ff      <= 2'd0;
         down_stamp_ff <= '0;
         up_stamp_ff   <= '0;
         armed_ff      <= 1'b0;
      end else if (advance && win_ok) begin
         is_down_ff    <= is_down_in;
         long_seen_ff  <= long_seen_in;
         tally_ff      <= tally_in;
         down_stamp_ff <= down_stamp_in;
         up_stamp_ff   <= up_stamp_in;
         armed_ff      <= armed_in;
      end
   end

   // result register
   logic       sig_valid_ff, evt_valid_ff;
   logic [1:0] kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sig_valid_ff <= win_ok;
         evt_valid_ff <= win_ok && fire;
         kind_ff      <= (win_ok && fire) ? kind : KIND_CLICK;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_signal_valid = sig_valid_ff;
   assign rsp_event_valid  = evt_valid_ff;
   assign rsp_click_kind   = kind_ff;

endmodule

// ----- hw/rtl/rcpc_checker.sv -----
module rcpc_checker
   import rcpc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_signal_valid,
   input logic       rsp_event_valid,
   input logic [1:0] rsp_click_kind
);

   // an event only comes from a valid pulse
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_valid |-> rsp_signal_valid)
      else $error("event reported on invalid pulse");

   // no event means click kind zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_event_valid |-> rsp_click_kind == KIND_CLICK)
      else $error("click kind set without event");

   // a rising rsp_valid follows the accepted req beat that caused it
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without request");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_signal_valid) &&
         $stable(rsp_event_valid) && $stable(rsp_click_kind))
      else $error("stalled response changed");

endmodule

bind rc_pulse_click_classifier_unit rcpc_checker u_rcpc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_signal_valid (rsp_signal_valid),
   .rsp_event_valid  (rsp_event_valid),
   .rsp_click_kind   (rsp_click_kind)
);

// ----- tb/tb_rc_pulse_click_classifier_unit.sv -----
`timescale 1ns / 100ps

module tb_rc_pulse_click_classifier_unit
   import rcpc_pkg::*;
();

   localparam int unsigned PULSE_W     = 16;
   localparam int unsigned STAMP_W     = 32;
   // cycles without any accepted beat before the run is declared hung
   localparam int unsigned STALL_LIMIT = 5000;
   // extra cycles that settle waits after both queues have drained
   localparam int unsigned DRAIN_SLACK = 4;

   // one rc frame as offered on the req channel
   typedef struct packed {
      logic [PULSE_W-1:0] width;
      logic [STAMP_W-1:0] stamp;
   } frame_type;

   // what the block should report for one frame
   typedef struct packed {
      logic           sig_ok;
      logic           gesture_done;
      click_kind_type kind;
   } verdict_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [PULSE_W-1:0]       req_pulse_width_us = '0;
   logic [STAMP_W-1:0]       req_now_ms = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_signal_valid;
   logic                     rsp_event_valid;
   logic [1:0]               rsp_click_kind;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   rc_pulse_click_classifier_unit #(
      .TIME_BITS (STAMP_W),
      .PULSE_BITS(PULSE_W)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pulse_width_us(req_pulse_width_us),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_signal_valid  (rsp_signal_valid),
      .rsp_event_valid   (rsp_event_valid),
      .rsp_click_kind    (rsp_click_kind),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // frames waiting to be offered, and verdicts waiting for their rsp beat
   frame_type   pending_q[$];
   verdict_type verdict_q[$];

   // idle / stall rates in percent, changed per phase
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;

   int unsigned fault_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned queued = 0;

   // shadow of the csr bank, loaded with the reset values
   logic [15:0] cfg_valid_low   = 16'd900;
   logic [15:0] cfg_valid_high  = 16'd2100;
   logic [7:0]  cfg_press_level = 8'd127;
   logic [15:0] cfg_long_ms     = 16'd1000;
   logic [15:0] cfg_double_ms   = 16'd300;

   // gesture tracking as the block should hold it
   logic        held           = 1'b0;
   logic        long_hold      = 1'b0;
   logic [1:0]  press_count    = 2'd0;
   logic [31:0] press_stamp    = '0;
   logic [31:0] lift_stamp     = '0;
   logic        single_pending = 1'b0;

   // stimulus timeline in ms, wraps like the real timestamp
   logic [31:0] sim_ms = '0;

   // ---------------------------------------------------------------
   // click classification: advances the gesture state by one frame
   // ---------------------------------------------------------------
   function automatic verdict_type classify_frame(input logic [PULSE_W-1:0] width,
                                                  input logic [STAMP_W-1:0] stamp);
      verdict_type v;
      int unsigned level;
      logic        pushed;
      logic [31:0] span;
      v = '{sig_ok: 1'b0, gesture_done: 1'b0, kind: KIND_CLICK};
      // outside the window (or an inverted window): report and touch nothing
      if (width < cfg_valid_low || width > cfg_valid_high)
         return v;
      v.sig_ok = 1'b1;
      // stick position 1000..2000 us onto 0..255, short pulses pinned at 0
      if (32'(width) < MAP_IN_LOW)
         level = 0;
      else
         level = ((32'(width) - MAP_IN_LOW) * MAP_OUT_MAX) / MAP_IN_SPAN;
      if (level > MAP_OUT_MAX)
         level = MAP_OUT_MAX;
      pushed = level > cfg_press_level;

      if (pushed && !held) begin
         held = 1'b1;
         press_stamp = stamp;
         if (press_count != TALLY_MAX)
            press_count = press_count + 2'd1;
      end else if (!pushed && held) begin
         held = 1'b0;
         lift_stamp = stamp;
         span = stamp - press_stamp;     // wraps mod 2^32
         if (span >= cfg_long_ms)
            long_hold = 1'b1;
         if (press_count == TALLY_ONE)
            single_pending = 1'b1;
      end

      span = stamp - lift_stamp;
      // a lone press waits out the double-click window, a second press ends on release
      if (!held && ((press_count == TALLY_ONE && single_pending && span > cfg_double_ms)
                    || press_count > TALLY_ONE)) begin
         v.gesture_done = 1'b1;
         if (long_hold && press_count > TALLY_ONE)
            v.kind = KIND_CLICK_LONG;
         else if (long_hold)
            v.kind = KIND_LONG;
         else if (press_count > TALLY_ONE)
            v.kind = KIND_DOUBLE;
         else
            v.kind = KIND_CLICK;
         single_pending = 1'b0;
         press_count = 2'd0;
         long_hold = 1'b0;
      end
      return v;
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   // narrowest pulse that maps above the press level
   function automatic int unsigned press_floor();
      return MAP_IN_LOW +
             ((32'(cfg_press_level) + 1) * MAP_IN_SPAN + MAP_OUT_MAX - 1) / MAP_OUT_MAX;
   endfunction

   // a valid width on the requested side of the press level, where one exists
   function automatic logic [15:0] pick_width(input bit want_press);
      int unsigned lo, hi, edge_w;
      edge_w = press_floor();
      if (want_press) begin
         lo = (edge_w > cfg_valid_low) ? edge_w : cfg_valid_low;
         hi = cfg_valid_high;
         // mostly near the stick range, now and then out to the window top
         if (hi > lo + 600 && $urandom_range(9) != 0)
            hi = lo + 600;
      end else begin
         lo = cfg_valid_low;
         hi = (cfg_valid_high < edge_w - 1) ? cfg_valid_high : edge_w - 1;
         if (hi > 800 && lo < 800 && $urandom_range(3) != 0)
            lo = 800;
      end
      if (lo > hi)
         return 16'($urandom_range(65535));
      return 16'($urandom_range(hi, lo));
   endfunction

   task automatic queue_frame(input logic [15:0] width, input logic [31:0] stamp);
      pending_q.push_back('{width: width, stamp: stamp});
      queued++;
   endtask

   // press / hold / release sequences with times around the csr limits
   task automatic queue_gesture();
      int unsigned presses, frames, hold, step, gap;
      logic [31:0] down_at;
      presses = $urandom_range(3, 1);
      for (int p = 0; p < presses; p++) begin
         down_at = sim_ms;
         queue_frame(pick_width(1'b1), sim_ms);
         case ($urandom_range(3))
            0:       hold = cfg_long_ms;
            1:       hold = (cfg_long_ms != 0) ? cfg_long_ms - 1 : 0;
            2:       hold = $urandom_range(cfg_long_ms, 1);
            default: hold = cfg_long_ms + $urandom_range(800);
         endcase
         // repeated frames while the stick stays up
         frames = $urandom_range(2);
         step = hold / (frames + 1);
         for (int f = 0; f < frames; f++) begin
            sim_ms = sim_ms + step;
            queue_frame(pick_width(1'b1), sim_ms);
         end
         sim_ms = down_at + hold;
         queue_frame(pick_width(1'b0), sim_ms);
         if (p + 1 < presses) begin
            case ($urandom_range(3))
               0:       gap = cfg_double_ms;
               1:       gap = cfg_double_ms + 1;
               default: gap = $urandom_range(cfg_double_ms, 1);
            endcase
            sim_ms = sim_ms + gap;
         end
      end
      // released frames; an optional last one lets a lone click time out
      frames = $urandom_range(3, 1);
      for (int f = 0; f < frames; f++) begin
         sim_ms = sim_ms + $urandom_range(cfg_double_ms / 2 + 20);
         queue_frame(pick_width(1'b0), sim_ms);
      end
      if ($urandom_range(1)) begin
         sim_ms = sim_ms + cfg_double_ms + 1;
         queue_frame(pick_width(1'b0), sim_ms);
      end
   endtask

   // out-of-window pulses, raw widths and timestamp jumps
   task automatic queue_noise();
      logic [15:0] width;
      case ($urandom_range(3))
         0: width = (cfg_valid_low != 0) ? 16'($urandom_range(cfg_valid_low - 1, 0))
                                          : 16'($urandom_range(65535));
         1: width = (cfg_valid_high != 16'hFFFF)
                    ? 16'($urandom_range(65535, cfg_valid_high + 1))
                    : 16'($urandom_range(65535));
         2: width = 16'($urandom_range(65535));
         default: begin
            sim_ms = $urandom();
            width = pick_width($urandom_range(1));
         end
      endcase
      sim_ms = sim_ms + $urandom_range(40);
      queue_frame(width, sim_ms);
   endtask

   task automatic queue_batch(input int unsigned count);
      int unsigned goal;
      goal = queued + count;
      while (queued < goal) begin
         if ($urandom_range(99) < 70)
            queue_gesture();
         else
            queue_noise();
      end
   endtask

   // hold off until the req side is empty and every verdict has been matched
   task automatic settle();
      do @(negedge clock);
      while (pending_q.size() != 0 || req_valid || verdict_q.size() != 0);
      repeat (DRAIN_SLACK) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      case (idx)
         CSR_VALID_LOW:   cfg_valid_low = val;
         CSR_VALID_HIGH:  cfg_valid_high = val;
         CSR_PRESS_LEVEL: cfg_press_level = val[7:0];
         CSR_LONG_PRESS:  cfg_long_ms = val;
         CSR_DOUBLE_CLK:  cfg_double_ms = val;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_regs(input logic [15:0] lo, input logic [15:0] hi,
                           input logic [7:0] lvl, input logic [15:0] long_v,
                           input logic [15:0] dbl_v);
      write_reg(CSR_VALID_LOW, lo);
      write_reg(CSR_VALID_HIGH, hi);
      write_reg(CSR_PRESS_LEVEL, {8'd0, lvl});
      write_reg(CSR_LONG_PRESS, long_v);
      write_reg(CSR_DOUBLE_CLK, dbl_v);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------
   // req driver: predicts on every accepted beat, then offers the next frame
   // ---------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      logic      offer;
      frame_type nxt;
      offer = req_valid;
      if (reset) begin
         offer = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            verdict_q.push_back(classify_frame(req_pulse_width_us, req_now_ms));
            offer = 1'b0;
         end
         // valid only drops after a handshake, so the idle roll is taken then
         if (!offer && pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_q.pop_front();
            req_pulse_width_us <= nxt.width;
            req_now_ms <= nxt.stamp;
            offer = 1'b1;
         end
      end
      req_valid <= offer;
   end

   // ---------------------------------------------------------------
   // rsp monitor: random back-pressure, compare against oldest verdict
   // ---------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_q.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("rsp beat with nothing outstanding: sv=%0b ev=%0b kind=%0d",
                        rsp_signal_valid, rsp_event_valid, rsp_click_kind);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_signal_valid !== want.sig_ok || rsp_event_valid !== want.gesture_done
                || rsp_click_kind !== want.kind) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("mismatch: expected sv=%0b ev=%0b kind=%0d, got sv=%0b ev=%0b kind=%0d",
                           want.sig_ok, want.gesture_done, want.kind,
                           rsp_signal_valid, rsp_event_valid, rsp_click_kind);
            end
         end
      end
      rsp_ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // watchdog: any beat on either channel counts as progress
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender sparse-ish, receiver stalls hard
      send_idle_pct = 24;
      stall_pct = 70;

      // directed frames at reset csr values (window 900..2100, level 127,
      // long 1000 ms, double 300 ms)
      queue_frame(16'd0,     32'd0);       // below window
      queue_frame(16'd65535, 32'd5);       // widest pulse, above window
      queue_frame(16'd899,   32'd10);      // one under the window
      queue_frame(16'd2101,  32'd12);      // one over the window
      queue_frame(16'd900,   32'd15);      // short pulse, maps to zero
      queue_frame(16'd1501,  32'd20);      // maps exactly to the level, not pressed
      queue_frame(16'd1502,  32'd30);      // first width above the level
      queue_frame(16'd2100,  32'd40);      // held at window top
      queue_frame(16'd1000,  32'd80);      // release, single-click wait armed
      queue_frame(16'd1200,  32'd380);     // wait exactly equal, no event yet
      queue_frame(16'd1200,  32'd381);     // wait exceeded, single click
      queue_frame(16'd1600,  32'd400);
      queue_frame(16'd1100,  32'd450);
      queue_frame(16'd1800,  32'd500);     // second press
      queue_frame(16'd1100,  32'd550);     // released, double click
      queue_frame(16'd2000,  32'd600);
      queue_frame(16'd1000,  32'd1600);    // held exactly the long limit
      queue_frame(16'd1000,  32'd1901);    // long press
      queue_frame(16'd1900,  32'd2000);
      queue_frame(16'd1000,  32'd2050);
      queue_frame(16'd1900,  32'd2100);
      queue_frame(16'd1000,  32'd3200);    // click then long press
      queue_frame(16'd2000,  32'hFFFF_FF00);
      queue_frame(16'd1000,  32'h0000_0300); // hold spans the timestamp wrap
      queue_frame(16'd1000,  32'h0000_0700); // long press after wrap
      sim_ms = 32'h0000_0800;
      settle();

      // sender waits for the full drain between the two halves
      queue_batch(120);
      settle();
      queue_batch(110);
      settle();

      // low extremes: everything valid, any nonzero level presses, every hold long
      set_regs(16'd0, 16'hFFFF, 8'd0, 16'd0, 16'd0);
      queue_batch(80);
      settle();

      // high extremes: nothing can press, longest times
      set_regs(16'd1000, 16'd2000, 8'd255, 16'hFFFF, 16'hFFFF);
      queue_batch(30);
      settle();

      // near-top level with the shortest nonzero times
      set_regs(16'd950, 16'd2050, 8'd254, 16'd1, 16'd1);
      queue_batch(50);
      settle();

      // inverted window: no pulse counts as valid
      set_regs(16'd2500, 16'd1500, 8'd127, 16'd1000, 16'd300);
      queue_batch(20);
      settle();

      // swap idling: sender idles hard, receiver mostly ready
      set_regs(16'($urandom_range(1000, 700)), 16'($urandom_range(2600, 2000)),
               8'($urandom_range(200, 60)), 16'($urandom_range(1500, 50)),
               16'($urandom_range(600, 50)));
      send_idle_pct = 70;
      stall_pct = 24;
      queue_batch(170);
      settle();

      // full rate on both sides
      set_regs(16'($urandom_range(1000, 700)), 16'($urandom_range(2600, 2000)),
               8'($urandom_range(200, 60)), 16'($urandom_range(1500, 50)),
               16'($urandom_range(600, 50)));
      send_idle_pct = 0;
      stall_pct = 0;
      queue_batch(170);
      settle();

      if (fault_count == 0 && verdict_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/rcpc_pkg.sv
hw/rtl/rc_pulse_click_classifier_unit.sv
hw/rtl/rcpc_checker.sv
tb/tb_rc_pulse_click_classifier_unit.sv
